[src/uqpd_pkg.sv]
// Shared constants, types and helper function of the URL query parameter decoder.
package uqpd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [4:0] NOT_HEX = 5'd16;

  localparam logic [7:0] NAME_CAP_RESET  = 8'd31;
  localparam logic [7:0] VALUE_CAP_RESET = 8'd63;

  localparam logic CFG_NAME_CAP  = 1'b0;
  localparam logic CFG_VALUE_CAP = 1'b1;

  localparam logic [2:0] STATUS_OK      = 3'd0;
  localparam logic [2:0] STATUS_NO_PAIR = 3'd4;

  typedef struct packed {
    logic [7:0] decoded_char;
    logic       in_value;
    logic       pair_end;
    logic [2:0] pair_status;
  } res_t;

  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = NOT_HEX;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = 5'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = 5'(b - 8'h41 + 8'd10);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = 5'(b - 8'h61 + 8'd10);
    end
    return v;
  endfunction

endpackage

[src/uqpd_core.sv]
// Per-byte decoding logic and pair state of the URL query parameter decoder.
module uqpd_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic [7:0]      text_byte,
  input  logic            end_of_text,
  input  logic [7:0]      name_cap,
  input  logic [7:0]      value_cap,
  output logic            res_valid,
  output uqpd_pkg::res_t  res
);

  typedef enum logic [1:0] {
    HEX_IDLE,
    HEX_FIRST,
    HEX_SECOND
  } hex_stage_t;

  hex_stage_t hex_stage_r, hex_stage_nxt;
  logic       value_phase_r, value_phase_nxt;
  logic [7:0] first_hex_r, first_hex_nxt;
  logic [7:0] name_count_r, name_count_nxt;
  logic [7:0] value_count_r, value_count_nxt;
  logic [1:0] ovf_r, ovf_nxt;
  logic       pair_open_r, pair_open_nxt;

  logic       emit_c;
  logic [7:0] char_c;
  logic [4:0] d1_c;
  logic [4:0] d2_c;

  always_comb begin
    hex_stage_nxt   = hex_stage_r;
    value_phase_nxt = value_phase_r;
    first_hex_nxt   = first_hex_r;
    name_count_nxt  = name_count_r;
    value_count_nxt = value_count_r;
    ovf_nxt         = ovf_r;
    pair_open_nxt   = pair_open_r;
    res_valid       = 1'b0;
    res             = '0;
    emit_c          = 1'b0;
    char_c          = text_byte;
    d1_c            = uqpd_pkg::hex_value(first_hex_r);
    d2_c            = uqpd_pkg::hex_value(text_byte);

    if (in_fire) begin
      if (end_of_text) begin
        res_valid       = 1'b1;
        res.pair_end    = 1'b1;
        res.pair_status = pair_open_r ? {1'b0, ovf_r} : uqpd_pkg::STATUS_NO_PAIR;
        hex_stage_nxt   = HEX_IDLE;
        value_phase_nxt = 1'b0;
        first_hex_nxt   = '0;
        name_count_nxt  = '0;
        value_count_nxt = '0;
        ovf_nxt         = '0;
        pair_open_nxt   = 1'b0;
      end else begin
        pair_open_nxt = 1'b1;
        unique case (hex_stage_r)
          HEX_FIRST: begin
            first_hex_nxt = text_byte;
            hex_stage_nxt = HEX_SECOND;
          end
          HEX_SECOND: begin
            hex_stage_nxt = HEX_IDLE;
            emit_c        = 1'b1;
            if (d1_c == uqpd_pkg::NOT_HEX) begin
              char_c = '0;
            end else if (d2_c == uqpd_pkg::NOT_HEX) begin
              char_c = {4'd0, d1_c[3:0]};
            end else begin
              char_c = {d1_c[3:0], d2_c[3:0]};
            end
          end
          default: begin
            hex_stage_nxt = HEX_IDLE;
            if (text_byte == uqpd_pkg::CH_AMP) begin
              res_valid       = 1'b1;
              res.pair_end    = 1'b1;
              res.pair_status = {1'b0, ovf_r};
              value_phase_nxt = 1'b0;
              first_hex_nxt   = '0;
              name_count_nxt  = '0;
              value_count_nxt = '0;
              ovf_nxt         = '0;
              pair_open_nxt   = 1'b0;
            end else if (text_byte == uqpd_pkg::CH_PERCENT) begin
              hex_stage_nxt = HEX_FIRST;
            end else if (text_byte == uqpd_pkg::CH_EQUALS && !value_phase_r) begin
              value_phase_nxt = 1'b1;
            end else begin
              emit_c = 1'b1;
              char_c = (text_byte == uqpd_pkg::CH_PLUS) ? uqpd_pkg::CH_SPACE : text_byte;
            end
          end
        endcase

        if (emit_c) begin
          if (value_phase_r) begin
            if (value_count_r < value_cap) begin
              value_count_nxt  = value_count_r + 8'd1;
              res_valid        = 1'b1;
              res.decoded_char = char_c;
              res.in_value     = 1'b1;
            end else begin
              ovf_nxt[1] = 1'b1;
            end
          end else begin
            if (name_count_r < name_cap) begin
              name_count_nxt   = name_count_r + 8'd1;
              res_valid        = 1'b1;
              res.decoded_char = char_c;
              res.in_value     = 1'b0;
            end else begin
              ovf_nxt[0] = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_stage_r   <= HEX_IDLE;
      value_phase_r <= 1'b0;
      first_hex_r   <= '0;
      name_count_r  <= '0;
      value_count_r <= '0;
      ovf_r         <= '0;
      pair_open_r   <= 1'b0;
    end else begin
      hex_stage_r   <= hex_stage_nxt;
      value_phase_r <= value_phase_nxt;
      first_hex_r   <= first_hex_nxt;
      name_count_r  <= name_count_nxt;
      value_count_r <= value_count_nxt;
      ovf_r         <= ovf_nxt;
      pair_open_r   <= pair_open_nxt;
    end
  end

  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && end_of_text) |=>
      (!pair_open_r && name_count_r == 8'd0 && value_count_r == 8'd0 && ovf_r == 2'd0))
    else $error("Pair state not cleared after end of text.");

  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.pair_end) |-> (res.decoded_char == 8'd0 && !res.in_value))
    else $error("Pair end carries character fields.");

  a_char_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.pair_end) |-> (res.pair_status == uqpd_pkg::STATUS_OK))
    else $error("Character result carries a status.");

  a_escape_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !end_of_text && hex_stage_r == HEX_FIRST) |-> !res_valid)
    else $error("First escape digit produced a result.");

endmodule

[src/uqpd_outbuf.sv]
// Two-entry result buffer that lets the decoder accept a byte while a result waits.
module uqpd_outbuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  uqpd_pkg::res_t  push_data,
  output logic            can_accept,
  output logic            out_valid,
  input  logic            out_ready,
  output uqpd_pkg::res_t  out_data
);

  logic           head_valid_r;
  logic           skid_valid_r;
  uqpd_pkg::res_t head_r;
  uqpd_pkg::res_t skid_r;
  logic           pop;

  assign pop        = head_valid_r && out_ready;
  assign can_accept = !skid_valid_r;
  assign out_valid  = head_valid_r;
  assign out_data   = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (head_valid_r && !pop) begin
      if (push) begin
        skid_valid_r <= 1'b1;
        skid_r       <= push_data;
      end
    end else if (skid_valid_r) begin
      head_valid_r <= 1'b1;
      head_r       <= skid_r;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= push;
      head_r       <= push_data;
    end
  end

  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> head_valid_r)
    else $error("Skid entry held without a head entry.");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("Result pushed into a full buffer.");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && pop) |=> (head_valid_r && !skid_valid_r))
    else $error("Skid entry not moved to the head.");

endmodule

[src/url_query_param_decoder.sv]
// Top level of the URL query parameter decoder.
// The decoder takes one query-string byte per cycle unless stalled and, for each
// transaction that yields a result, presents it from the buffer's head register; a
// byte passes through combinational per-byte logic to the result register, and a
// two-entry result buffer keeps input accepted at one byte per clock while a result
// waits. Input stalls only when both buffer entries are full. The capacities reset to
// 31 name and 63 value characters and are written through cfg index 0 and 1; the
// user must do so only while no transaction is in flight; no check enforces this.
module url_query_param_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_decoded_char,
  output logic       out_in_value,
  output logic       out_pair_end,
  output logic [2:0] out_pair_status,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic [7:0]     name_cap_r;
  logic [7:0]     value_cap_r;
  logic           in_fire;
  logic           res_valid;
  uqpd_pkg::res_t res;
  uqpd_pkg::res_t out_res;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_cap_r  <= uqpd_pkg::NAME_CAP_RESET;
      value_cap_r <= uqpd_pkg::VALUE_CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uqpd_pkg::CFG_NAME_CAP:  name_cap_r  <= cfg_wdata;
        uqpd_pkg::CFG_VALUE_CAP: value_cap_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  uqpd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .text_byte   (in_text_byte),
    .end_of_text (in_end_of_text),
    .name_cap    (name_cap_r),
    .value_cap   (value_cap_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  uqpd_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .can_accept (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_res)
  );

  assign out_decoded_char = out_res.decoded_char;
  assign out_in_value     = out_res.in_value;
  assign out_pair_end     = out_res.pair_end;
  assign out_pair_status  = out_res.pair_status;

endmodule

[dv/tb_url_query_param_decoder.sv]
// Self-checking testbench that streams query strings into the URL query parameter decoder.
module tb_url_query_param_decoder;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int HOLD_OFF_AFTER = 300;
  localparam logic [1:0] OVF_NAME = 2'b01;
  localparam logic [1:0] OVF_VALUE = 2'b10;
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_FIRST = 2'd1;
  localparam logic [1:0] ESC_SECOND = 2'd2;

  typedef struct {
    logic [7:0] text_byte;
    logic end_of_text;
  } query_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_text_byte = 8'h00;
  logic in_end_of_text = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_decoded_char;
  logic out_in_value;
  logic out_pair_end;
  logic [2:0] out_pair_status;
  logic cfg_we = 1'b0;
  logic cfg_index = uqpd_pkg::CFG_NAME_CAP;
  logic [7:0] cfg_wdata = 8'h00;

  query_item_t query_q[$];
  uqpd_pkg::res_t decoded_q[$];
  int bytes_queued = 0;
  int bytes_taken = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit hold_done = 0;
  bit no_gaps = 0;

  logic [7:0] name_cap = uqpd_pkg::NAME_CAP_RESET;
  logic [7:0] value_cap = uqpd_pkg::VALUE_CAP_RESET;
  logic in_value_phase = 1'b0;
  logic [1:0] esc_stage = ESC_NONE;
  logic [7:0] esc_first = 8'h00;
  logic [7:0] name_kept = 8'h00;
  logic [7:0] value_kept = 8'h00;
  logic [1:0] ovf = 2'b00;
  logic pair_seen = 1'b0;

  url_query_param_decoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_text_byte(in_text_byte),
    .in_end_of_text(in_end_of_text),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_decoded_char(out_decoded_char),
    .out_in_value(out_in_value),
    .out_pair_end(out_pair_end),
    .out_pair_status(out_pair_status),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
    return uqpd_pkg::NOT_HEX;
  endfunction

  task automatic push_end(input logic [2:0] status);
    uqpd_pkg::res_t r;
    r.decoded_char = 8'h00;
    r.in_value = 1'b0;
    r.pair_end = 1'b1;
    r.pair_status = status;
    decoded_q.push_back(r);
  endtask

  task automatic clear_pair_state();
    in_value_phase = 1'b0;
    esc_stage = ESC_NONE;
    esc_first = 8'h00;
    name_kept = 8'h00;
    value_kept = 8'h00;
    ovf = 2'b00;
    pair_seen = 1'b0;
  endtask

  task automatic keep_char(input logic [7:0] c);
    uqpd_pkg::res_t r;
    if (in_value_phase) begin
      if (value_kept < value_cap) begin
        value_kept = value_kept + 8'd1;
      end else begin
        ovf = ovf | OVF_VALUE;
        return;
      end
    end else begin
      if (name_kept < name_cap) begin
        name_kept = name_kept + 8'd1;
      end else begin
        ovf = ovf | OVF_NAME;
        return;
      end
    end
    r.decoded_char = c;
    r.in_value = in_value_phase;
    r.pair_end = 1'b0;
    r.pair_status = uqpd_pkg::STATUS_OK;
    decoded_q.push_back(r);
  endtask

  task automatic decode_step(input logic [7:0] b, input logic eot);
    logic [4:0] d1;
    logic [4:0] d2;
    if (eot) begin
      push_end(pair_seen ? {1'b0, ovf} : uqpd_pkg::STATUS_NO_PAIR);
      clear_pair_state();
      return;
    end
    pair_seen = 1'b1;
    if (esc_stage == ESC_FIRST) begin
      esc_first = b;
      esc_stage = ESC_SECOND;
      return;
    end
    if (esc_stage == ESC_SECOND) begin
      esc_stage = ESC_NONE;
      d1 = digit_of(esc_first);
      d2 = digit_of(b);
      if (d1 == uqpd_pkg::NOT_HEX) keep_char(8'h00);
      else if (d2 == uqpd_pkg::NOT_HEX) keep_char(8'(d1));
      else keep_char(8'({d1[3:0], d2[3:0]}));
      return;
    end
    if (b == uqpd_pkg::CH_AMP) begin
      push_end({1'b0, ovf});
      clear_pair_state();
    end else if (b == uqpd_pkg::CH_PERCENT) begin
      esc_stage = ESC_FIRST;
    end else if (b == uqpd_pkg::CH_EQUALS && !in_value_phase) begin
      in_value_phase = 1'b1;
    end else begin
      keep_char(b == uqpd_pkg::CH_PLUS ? uqpd_pkg::CH_SPACE : b);
    end
  endtask

  always @(posedge clk) begin : drive
    query_item_t nxt;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        decode_step(in_text_byte, in_end_of_text);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (query_q.size() != 0 && (no_gaps || $urandom_range(99) >= 16)) begin
          nxt = query_q.pop_front();
          in_valid <= 1'b1;
          in_text_byte <= nxt.text_byte;
          in_end_of_text <= nxt.end_of_text;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receive
    uqpd_pkg::res_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("Result arrived with no transaction waiting for it.");
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          if (out_decoded_char !== want.decoded_char) begin
            $error("decoded_char: expected %0h, got %0h", want.decoded_char, out_decoded_char);
            mismatches++;
          end
          if (out_in_value !== want.in_value) begin
            $error("in_value: expected %0b, got %0b", want.in_value, out_in_value);
            mismatches++;
          end
          if (out_pair_end !== want.pair_end) begin
            $error("pair_end: expected %0b, got %0b", want.pair_end, out_pair_end);
            mismatches++;
          end
          if (out_pair_status !== want.pair_status) begin
            $error("pair_status: expected %0d, got %0d", want.pair_status, out_pair_status);
            mismatches++;
          end
        end
      end
      if (!hold_done && bytes_taken >= HOLD_OFF_AFTER) begin
        hold_done = 1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_gaps || ($urandom_range(99) >= 16);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic add_item(input logic [7:0] b, input logic e);
    query_item_t it;
    it.text_byte = b;
    it.end_of_text = e;
    query_q.push_back(it);
    bytes_queued++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] hex_char();
    string digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(21)];
  endfunction

  task automatic add_chars(input int n, input bit value_side);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 55) begin
        add_item(8'($urandom_range(8'h61, 8'h7a)), 1'b0);
      end else if (k < 65) begin
        add_item(uqpd_pkg::CH_PLUS, 1'b0);
      end else if (k < 85) begin
        add_item(uqpd_pkg::CH_PERCENT, 1'b0);
        add_item($urandom_range(4) == 0 ? 8'($urandom_range(255)) : hex_char(), 1'b0);
        add_item($urandom_range(3) == 0 ? 8'($urandom_range(255)) : hex_char(), 1'b0);
      end else if (k < 92) begin
        add_item(value_side ? uqpd_pkg::CH_EQUALS : 8'($urandom_range(8'h41, 8'h5a)), 1'b0);
      end else begin
        add_item(8'($urandom_range(8'h80, 8'hff)), 1'b0);
      end
    end
  endtask

  task automatic add_query();
    int pairs;
    int tail;
    pairs = $urandom_range(1, 4);
    for (int p = 0; p < pairs; p++) begin
      if (p > 0) add_item(uqpd_pkg::CH_AMP, 1'b0);
      add_chars($urandom_range(9) == 0 ? $urandom_range(20, 40) : $urandom_range(0, 6), 0);
      if ($urandom_range(9) != 0) begin
        add_item(uqpd_pkg::CH_EQUALS, 1'b0);
        add_chars($urandom_range(9) == 0 ? $urandom_range(40, 70) : $urandom_range(0, 8), 1);
      end
    end
    tail = $urandom_range(19);
    if (tail == 0) begin
      add_item(uqpd_pkg::CH_PERCENT, 1'b0);
    end else if (tail == 1) begin
      add_item(uqpd_pkg::CH_PERCENT, 1'b0);
      add_item(hex_char(), 1'b0);
    end else if (tail == 2) begin
      add_item(uqpd_pkg::CH_AMP, 1'b0);
    end
    if (tail != 3) add_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic gen_random(input int n);
    int target;
    target = bytes_queued + n;
    while (bytes_queued < target) begin
      if ($urandom_range(99) < 15) begin
        for (int i = $urandom_range(1, 12); i > 0; i--) begin
          add_item(8'($urandom_range(255)), $urandom_range(19) == 0);
        end
      end else begin
        add_query();
      end
    end
  endtask

  task automatic wait_idle();
    while (query_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cap(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == uqpd_pkg::CFG_NAME_CAP) name_cap = val;
    else value_cap = val;
  endtask

  task automatic set_phase(input logic [7:0] ncap, input logic [7:0] vcap, input bit gapless);
    wait_idle();
    write_cap(uqpd_pkg::CFG_NAME_CAP, ncap);
    write_cap(uqpd_pkg::CFG_VALUE_CAP, vcap);
    no_gaps = gapless;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    add_item(8'h41, 1'b1);
    add_text("a=b&&");
    add_text("k=x=+");
    add_item(8'h00, 1'b1);
    add_text("%41%6a%4g%zz%&=");
    add_item(8'h00, 1'b0);
    add_item(8'hff, 1'b0);
    add_item(8'h00, 1'b1);
    add_text("%4");
    add_item(8'h26, 1'b1);
    gen_random(200);

    set_phase(8'd255, 8'd255, 0);
    gen_random(250);
    set_phase(8'd0, 8'd0, 0);
    add_text("x=y");
    add_item(8'h00, 1'b1);
    gen_random(150);
    set_phase(8'd2, 8'd3, 1);
    add_text("ab=cd&");
    gen_random(200);
    set_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 0);
    gen_random(200);
    set_phase(8'd5, 8'd0, 0);
    gen_random(100);
    set_phase(uqpd_pkg::NAME_CAP_RESET, uqpd_pkg::VALUE_CAP_RESET, 0);
    gen_random(150);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
src/uqpd_pkg.sv
src/uqpd_core.sv
src/uqpd_outbuf.sv
src/url_query_param_decoder.sv
dv/tb_url_query_param_decoder.sv
